### rtl/dmem_pkg.sv
// shared types and constants of the depth motion energy meter
// no dependencies
package dmem_pkg;

    localparam int DEPTH_W   = 13;
    localparam int PPC_W     = 12;
    localparam int TOTAL_W   = 27;
    localparam int LEVEL_W   = 16;
    localparam int S_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PPC       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HIGH  = 2'd3;

    localparam logic [PPC_W-1:0]   PPC_RST      = 12'd768;
    localparam logic [DEPTH_W-1:0] JUMP_RST     = 13'd2700;
    localparam logic [DEPTH_W-1:0] MAP_LOW_RST  = 13'd30;
    localparam logic [DEPTH_W-1:0] MAP_HIGH_RST = 13'd130;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    typedef struct packed {
        logic clear;
        logic capture;
        logic walk;
        logic accum;
        logic mul_div;
        logic mul_map;
        logic sub_num;
        logic norm;
        logic check;
        logic prep;
        logic div_step;
        logic out_load;
        logic frame_done;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic rd_last;
        logic last;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/dmem_ctrl.sv
// sequencer of the depth motion energy meter
// depends on dmem_pkg, drives the commands of dmem_datapath
module dmem_ctrl
    import dmem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    input  t_dp_sts i_sts,
    output logic    o_s_axis_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_ACCUM,
        ST_MUL1,
        ST_MUL2,
        ST_SUBT,
        ST_NORM,
        ST_CHECK,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_CLEAR: if (i_sts.clear_done) r_state <= ST_IDLE;
                ST_IDLE:  if (i_s_axis_tvalid) r_state <= ST_WALK;
                ST_WALK:  if (i_sts.rd_last) r_state <= ST_DRAIN;
                ST_DRAIN: r_state <= ST_ACCUM;
                ST_ACCUM: r_state <= i_sts.last ? ST_MUL1 : ST_IDLE;
                ST_MUL1:  r_state <= ST_MUL2;
                ST_MUL2:  r_state <= ST_SUBT;
                ST_SUBT:  r_state <= ST_NORM;
                ST_NORM:  r_state <= ST_CHECK;
                ST_CHECK: r_state <= i_sts.need_div ? ST_PREP : ST_OUT;
                ST_PREP:  r_state <= ST_DIV;
                ST_DIV:   if (i_sts.div_last) r_state <= ST_OUT;
                ST_OUT:   if (i_sts.out_free) r_state <= ST_IDLE;
                default:  r_state <= ST_CLEAR;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear      = (r_state == ST_CLEAR);
        o_cmd.capture    = (r_state == ST_IDLE) && i_s_axis_tvalid;
        o_cmd.walk       = (r_state == ST_WALK);
        o_cmd.accum      = (r_state == ST_ACCUM);
        o_cmd.mul_div    = (r_state == ST_MUL1);
        o_cmd.mul_map    = (r_state == ST_MUL2);
        o_cmd.sub_num    = (r_state == ST_SUBT);
        o_cmd.norm       = (r_state == ST_NORM);
        o_cmd.check      = (r_state == ST_CHECK);
        o_cmd.prep       = (r_state == ST_PREP);
        o_cmd.div_step   = (r_state == ST_DIV);
        o_cmd.out_load   = (r_state == ST_OUT) && i_sts.out_free;
        o_cmd.frame_done = (r_state == ST_OUT) && i_sts.out_free;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

endmodule

### rtl/dmem_datapath.sv
// history memory, motion accumulation, level mapping and output register
// depends on dmem_pkg, sequenced by dmem_ctrl
module dmem_datapath
    import dmem_pkg::*;
#(
    parameter int HISTORY_FRAMES = 15,
    parameter int MAX_POINTS     = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [DEPTH_W-1:0]   i_depth,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_m_ready,
    output logic                 o_m_valid,
    output logic [LEVEL_W-1:0]   o_m_level
);

    localparam int SW        = $clog2(HISTORY_FRAMES);
    localparam int PW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW        = PW + SW;
    localparam int MEM_DEPTH = MAX_POINTS << SW;
    localparam int DIV_W     = PPC_W + SW;
    localparam int ACC_W     = DEPTH_W + SW;
    localparam int PROD_W    = DEPTH_W + DIV_W;
    localparam int NW        = ((TOTAL_W > PROD_W) ? TOTAL_W : PROD_W) + 2;

    logic [PPC_W-1:0]   r_ppc;
    logic [DEPTH_W-1:0] r_jump;
    logic [DEPTH_W-1:0] r_map_low;
    logic [DEPTH_W-1:0] r_map_high;

    logic [DEPTH_W-1:0] r_mem [MEM_DEPTH];
    logic [DEPTH_W-1:0] r_rd_data;
    logic [AW-1:0]      r_clr_addr;
    logic [PW-1:0]      r_pos;
    logic [SW-1:0]      r_slot;
    logic [SW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic               r_rd_first;
    logic               r_last;
    logic [DEPTH_W-1:0] r_first;
    logic [DEPTH_W-1:0] r_prev;
    logic [ACC_W-1:0]   r_acc;
    logic [TOTAL_W-1:0] r_total;

    logic [DIV_W-1:0]     r_div;
    logic [PROD_W-1:0]    r_low_prod;
    logic signed [NW-1:0] r_num;
    logic signed [NW-1:0] r_den;
    logic [NW-1:0]        r_rem;
    logic [15:0]          r_nlow;
    logic [3:0]           r_bit_cnt;
    logic [LEVEL_W-1:0]   r_level;
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_data;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DEPTH_W-1:0]   mem_wdata;
    logic [DEPTH_W-1:0]   walk_diff;
    logic [DEPTH_W-1:0]   wrap_diff;
    logic [ACC_W-1:0]     point_sum;
    logic [TOTAL_W:0]     total_sum;
    logic signed [DEPTH_W:0]       map_span;
    logic signed [PROD_W+1:0]      den_prod;
    logic [NW+15:0]                n_big;
    logic [NW:0]                   div_trial;
    logic [NW:0]                   div_den;

    function automatic logic [DEPTH_W-1:0] gated_diff(
        input logic [DEPTH_W-1:0] a,
        input logic [DEPTH_W-1:0] b,
        input logic [DEPTH_W-1:0] lim
    );
        logic [DEPTH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d < lim) ? d : '0;
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppc      <= PPC_RST;
            r_jump     <= JUMP_RST;
            r_map_low  <= MAP_LOW_RST;
            r_map_high <= MAP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PPC:      r_ppc      <= i_cfg_data[PPC_W-1:0];
                REG_JUMP:     r_jump     <= i_cfg_data;
                REG_MAP_LOW:  r_map_low  <= i_cfg_data;
                REG_MAP_HIGH: r_map_high <= i_cfg_data;
                default:      r_ppc      <= r_ppc;
            endcase
        end
    end

    // history memory
    assign mem_we    = i_cmd.clear || i_cmd.capture;
    assign mem_waddr = i_cmd.clear ? r_clr_addr : {r_pos, r_slot};
    assign mem_wdata = i_cmd.clear ? '0 : i_depth;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[{r_pos, r_rd_idx}];
    end

    assign walk_diff = gated_diff(r_prev, r_rd_data, r_jump);
    assign wrap_diff = gated_diff(r_prev, r_first, r_jump);
    assign point_sum = r_acc + ACC_W'(wrap_diff);
    assign total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(point_sum);

    // per point walk and frame total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pos      <= '0;
            r_slot     <= '0;
            r_rd_idx   <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_last     <= 1'b0;
            r_total    <= '0;
        end else begin
            r_rd_vld <= i_cmd.walk;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.capture) begin
                r_rd_idx <= '0;
                r_last   <= i_last;
            end else if (i_cmd.walk) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_rd_first <= (r_rd_idx == '0);
            if (i_cmd.accum) begin
                r_total <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                r_pos   <= (r_pos == PW'(MAX_POINTS - 1)) ? '0 : r_pos + 1'b1;
            end
            if (i_cmd.frame_done) begin
                r_total <= '0;
                r_pos   <= '0;
                r_slot  <= (r_slot == SW'(HISTORY_FRAMES - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_prev <= r_rd_data;
            if (r_rd_first) begin
                r_first <= r_rd_data;
            end else begin
                r_acc <= r_acc + ACC_W'(walk_diff);
            end
        end
    end

    // level mapping
    assign map_span  = $signed({1'b0, r_map_high}) - $signed({1'b0, r_map_low});
    assign den_prod  = (PROD_W + 2)'(map_span) * (PROD_W + 2)'($signed({1'b0, r_div}));
    assign n_big     = {r_num, 16'h0} - {16'h0, r_num};
    assign div_trial = {r_rem, r_nlow[15]};
    assign div_den   = {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_div) begin
            r_div <= DIV_W'(r_ppc * HISTORY_FRAMES);
        end
        if (i_cmd.mul_map) begin
            r_low_prod <= PROD_W'(r_map_low) * PROD_W'(r_div);
            r_den      <= NW'(den_prod);
        end
        if (i_cmd.sub_num) begin
            r_num <= $signed({{(NW - TOTAL_W){1'b0}}, r_total})
                   - $signed({{(NW - PROD_W){1'b0}}, r_low_prod});
        end
        if (i_cmd.norm && r_den < 0) begin
            r_den <= -r_den;
            r_num <= -r_num;
        end
        if (i_cmd.check) begin
            r_level <= (r_den != 0 && r_num > 0 && r_num >= r_den) ? LEVEL_MAX : '0;
        end
        if (i_cmd.prep) begin
            r_rem     <= n_big[NW+15:16];
            r_nlow    <= n_big[15:0];
            r_bit_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_nlow    <= {r_nlow[14:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + 1'b1;
            if (div_trial >= div_den) begin
                r_rem   <= NW'(div_trial - div_den);
                r_level <= {r_level[LEVEL_W-2:0], 1'b1};
            end else begin
                r_rem   <= div_trial[NW-1:0];
                r_level <= {r_level[LEVEL_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_load || (r_out_valid && !i_m_ready);
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_level;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_level = r_out_data;

    always_comb begin
        o_sts            = '0;
        o_sts.clear_done = (r_clr_addr == AW'(MEM_DEPTH - 1));
        o_sts.rd_last    = (r_rd_idx == SW'(HISTORY_FRAMES - 1));
        o_sts.last       = r_last;
        o_sts.need_div   = (r_den != 0) && (r_num > 0) && (r_num < r_den);
        o_sts.div_last   = (r_bit_cnt == 4'hF);
        o_sts.out_free   = !r_out_valid || i_m_ready;
    end

endmodule

### rtl/depth_motion_energy_meter_top.sv
// depth motion energy meter: one request per depth sample, one level per frame
// a sample walks the history of its point with one history read a cycle
// a frame end adds the level mapping and the 16-step divider, which is skipped when no division is needed
// reset zeroes all MAX_POINTS * 2^ceil(log2(HISTORY_FRAMES)) history words (32768 default)
// uses dmem_pkg, dmem_ctrl and dmem_datapath
module depth_motion_energy_meter_top
    import dmem_pkg::*;
#(
    parameter int HISTORY_FRAMES = 15,
    parameter int MAX_POINTS     = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [12:0] depth_mm, rest zero
    input  logic                 i_s_axis_tlast,  // frame_end
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [LEVEL_W-1:0]   o_m_axis_tdata,  // [15:0] motion_level
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dmem_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_sts           (sts),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd)
    );

    dmem_datapath #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .MAX_POINTS     (MAX_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_depth    (i_s_axis_tdata[DEPTH_W-1:0]),
        .i_last     (i_s_axis_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_ready  (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_level  (o_m_axis_tdata)
    );

endmodule

### test/dmem_level_checker.sv
// level checker for the depth motion energy meter: keeps its own history, slot and
// frame total, predicts the motion level of every frame and compares it with the level stream
// uses dmem_pkg
module dmem_level_checker
    import dmem_pkg::*;
#(
    parameter int HISTORY_FRAMES = 15,
    parameter int MAX_POINTS     = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [12:0] depth_mm, rest zero
    input  logic                 i_s_tlast,  // frame_end
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [LEVEL_W-1:0]   i_m_tdata,  // [15:0] motion_level
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_err_count,
    output int                   o_pending,
    output int                   o_level_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DEPTH_W-1:0] depth_hist [MAX_POINTS*HISTORY_FRAMES];
    int unsigned        cur_slot;
    int unsigned        cur_point;
    logic [TOTAL_W-1:0] frame_total;
    logic [PPC_W-1:0]   points_cfg;
    logic [DEPTH_W-1:0] jump_cfg;
    logic [DEPTH_W-1:0] map_low_cfg;
    logic [DEPTH_W-1:0] map_high_cfg;
    logic [LEVEL_W-1:0] expected_levels [$];
    int                 err_count;
    int                 level_count;

    // cyclic sum of slot to slot changes of one point, jumps at or above the limit dropped
    function automatic int unsigned point_motion(input int unsigned base);
        int unsigned sum;
        int unsigned a;
        int unsigned b;
        int unsigned d;
        sum = 0;
        for (int unsigned k = 0; k < HISTORY_FRAMES; k++) begin
            a = depth_hist[base + k];
            b = depth_hist[base + ((k + 1 < HISTORY_FRAMES) ? k + 1 : 0)];
            d = (a > b) ? a - b : b - a;
            if (d < jump_cfg)
                sum += d;
        end
        return sum;
    endfunction

    function automatic logic [LEVEL_W-1:0] frame_level();
        longint divisor;
        longint num;
        longint den;
        longint scaled;
        divisor = longint'(HISTORY_FRAMES) * longint'(points_cfg);
        num = longint'(frame_total) - longint'(map_low_cfg) * divisor;
        den = (longint'(map_high_cfg) - longint'(map_low_cfg)) * divisor;
        if (den == 0)
            return '0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0)
            return '0;
        if (num >= den)
            return LEVEL_MAX;
        scaled = (num * 65535) / den;
        return scaled[LEVEL_W-1:0];
    endfunction

    // newest level at the front, oldest taken from the back
    function automatic void take_sample(input logic [DEPTH_W-1:0] depth, input logic last);
        int unsigned base;
        int unsigned m;
        base = cur_point * HISTORY_FRAMES;
        depth_hist[base + cur_slot] = depth;
        m = point_motion(base);
        if (m > TOTAL_MAX - frame_total)
            frame_total = TOTAL_MAX;
        else
            frame_total = TOTAL_W'(frame_total + m);
        cur_point = (cur_point + 1 < MAX_POINTS) ? cur_point + 1 : 0;
        if (last) begin
            expected_levels.push_front(frame_level());
            frame_total = '0;
            cur_point   = 0;
            cur_slot    = (cur_slot + 1 < HISTORY_FRAMES) ? cur_slot + 1 : 0;
        end
    endfunction

    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] want;
        if (!i_rst_n) begin
            foreach (depth_hist[k])
                depth_hist[k] = '0;
            cur_slot     = 0;
            cur_point    = 0;
            frame_total  = '0;
            points_cfg   = PPC_RST;
            jump_cfg     = JUMP_RST;
            map_low_cfg  = MAP_LOW_RST;
            map_high_cfg = MAP_HIGH_RST;
            expected_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PPC:      points_cfg   = i_cfg_data[PPC_W-1:0];
                    REG_JUMP:     jump_cfg     = i_cfg_data[DEPTH_W-1:0];
                    REG_MAP_LOW:  map_low_cfg  = i_cfg_data[DEPTH_W-1:0];
                    REG_MAP_HIGH: map_high_cfg = i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                level_count++;
                if (expected_levels.size() == 0) begin
                    if (err_count < 10)
                        $display("%t: motion level %0d with no frame pending", $realtime,
                                 i_m_tdata);
                    err_count++;
                end else begin
                    want = expected_levels.pop_back();
                    if (i_m_tdata !== want) begin
                        if (err_count < 10)
                            $display("%t: motion level mismatch, expected %0d, got %0d",
                                     $realtime, want, i_m_tdata);
                        err_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_sample(i_s_tdata[DEPTH_W-1:0], i_s_tlast);
        end
        o_err_count   <= err_count;
        o_pending     <= expected_levels.size();
        o_level_count <= level_count;
    end

endmodule

### test/testbench.sv
// top of the depth motion energy meter test: clock, reset, sample and level streams,
// register writes and the verdict; directed frames, random frames and one long frame
// uses dmem_pkg, depth_motion_energy_meter_top and dmem_level_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dmem_pkg::*;

    localparam int HIST_FRAMES    = 15;
    localparam int POINT_LIMIT    = 2048;
    localparam int DEPTH_MAX      = 2**DEPTH_W - 1;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int LONG_FRAME     = 200;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [LEVEL_W-1:0]   m_tdata;
    int                   err_count;
    int                   pending;
    int                   level_count;

    int sent_items    = 0;
    int sent_frames   = 0;
    int settings_used = 0;
    int quiet_items   = 0;
    int idle_cycles   = 0;

    depth_motion_energy_meter_top #(
        .HISTORY_FRAMES (HIST_FRAMES),
        .MAX_POINTS     (POINT_LIMIT)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    dmem_level_checker #(
        .HISTORY_FRAMES (HIST_FRAMES),
        .MAX_POINTS     (POINT_LIMIT)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_err_count   (err_count),
        .o_pending     (pending),
        .o_level_count (level_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_sample(input logic [DEPTH_W-1:0] depth, input logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(depth);
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sent_items++;
        if (last)
            sent_frames++;
        if (quiet_items > 0) begin
            quiet_items--;
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sample stream until every frame level has come back
    task automatic drain(input logic settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [PPC_W-1:0] ppc, input logic [CFG_W-1:0] jump,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        drain(1'b1);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_PPC;
        cfg_data <= CFG_W'(ppc);
        @(posedge clk);
        cfg_idx  <= REG_JUMP;
        cfg_data <= jump;
        @(posedge clk);
        cfg_idx  <= REG_MAP_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_idx  <= REG_MAP_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int unsigned run;
        int unsigned stall;
        @(posedge clk);
        forever begin
            run = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int                goal;
        int                phase_end;
        int                base;
        int                d;
        int unsigned       noise;
        int unsigned       len;
        int unsigned       r;
        logic [PPC_W-1:0]  ppc;
        logic [CFG_W-1:0]  jump;
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        logic [DEPTH_W-1:0] depth;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, extreme depths
        send_sample(13'd8191, 1'b0);
        send_sample(13'd0, 1'b0);
        send_sample(13'd4660, 1'b0);
        send_sample(13'd8191, 1'b1);
        // one point per camera, widest map and jump limit
        load_config(12'd1, 13'd8191, 13'd0, 13'd8191);
        send_sample(13'd0, 1'b0);
        send_sample(13'd8191, 1'b0);
        send_sample(13'd4095, 1'b1);
        send_sample(13'd8190, 1'b1);
        send_sample(13'd1, 1'b1);
        send_sample(13'd5461, 1'b0);
        send_sample(13'd2730, 1'b1);
        // zero divisor
        load_config(12'd0, 13'd2700, 13'd30, 13'd130);
        send_sample(13'd1000, 1'b0);
        send_sample(13'd3000, 1'b1);
        // every jump dropped, equal map bounds
        load_config(12'd2, 13'd0, 13'd100, 13'd100);
        send_sample(13'd500, 1'b0);
        send_sample(13'd7000, 1'b1);
        // widest divisor, reversed map bounds
        load_config(12'd4095, 13'd100, 13'd8191, 13'd0);
        send_sample(13'd123, 1'b0);
        send_sample(13'd456, 1'b0);
        send_sample(13'd789, 1'b1);
        // narrowest map, level clamps at full scale
        load_config(12'd3, 13'd4000, 13'd0, 13'd1);
        send_sample(13'd8191, 1'b0);
        send_sample(13'd0, 1'b0);
        send_sample(13'd8191, 1'b1);
        send_sample(13'd4096, 1'b1);

        goal = sent_items + RANDOM_ITEMS;
        while (sent_items < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                ppc = PPC_W'($urandom_range(1, 8));
            else if (r < 90)
                ppc = PPC_W'($urandom_range(9, 2048));
            else if (r < 95)
                ppc = PPC_W'($urandom_range(2049, 4095));
            else
                ppc = '0;
            r = $urandom_range(0, 99);
            if (r < 80)
                jump = CFG_W'($urandom_range(1, 8191));
            else if (r < 90)
                jump = '0;
            else
                jump = '1;
            lo = CFG_W'($urandom_range(0, 300));
            hi = CFG_W'(lo + $urandom_range(1, 3000));
            r = $urandom_range(0, 99);
            if (r < 10)
                {lo, hi} = {hi, lo};
            else if (r < 15)
                hi = lo;
            else if (r < 25) begin
                lo = CFG_W'($urandom);
                hi = CFG_W'($urandom);
            end
            load_config(ppc, jump, lo, hi);

            noise = $urandom_range(0, 1500);
            base  = $urandom_range(0, DEPTH_MAX);
            phase_end = sent_items + $urandom_range(60, 140);
            while (sent_items < phase_end) begin
                base = base + int'($urandom_range(0, 400)) - 200;
                if (base < 0)
                    base = 0;
                else if (base > DEPTH_MAX)
                    base = DEPTH_MAX;
                len = $urandom_range(1, 12);
                for (int unsigned k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        d = base + int'($urandom_range(0, 2 * noise)) - int'(noise);
                        if (d < 0)
                            d = 0;
                        else if (d > DEPTH_MAX)
                            d = DEPTH_MAX;
                        depth = DEPTH_W'(d);
                    end else if (r < 85) begin
                        depth = DEPTH_W'($urandom_range(0, DEPTH_MAX));
                    end else if (r < 93) begin
                        depth = '0;
                    end else begin
                        depth = '1;
                    end
                    send_sample(depth, k == len - 1);
                end
                if ($urandom_range(0, 9) == 0)
                    drain(1'b0);
                if ($urandom_range(0, 19) == 0)
                    quiet_items = $urandom_range(20, 80);
            end
        end

        // one long frame of large depths over many fresh points
        load_config(12'd2048, '1, '0, '1);
        for (int k = 0; k < LONG_FRAME; k++)
            send_sample(DEPTH_W'($urandom_range(8000, 8190)), k == LONG_FRAME - 1);
        send_sample(13'd3000, 1'b0);
        send_sample(13'd5000, 1'b1);

        drain(1'b1);
        $display("sent %0d depth samples in %0d frames under %0d register settings",
                 sent_items, sent_frames, settings_used);
        $display("compared %0d motion levels, longest frame %0d samples",
                 level_count, LONG_FRAME);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
